### design/pwc_pkg.sv
// Shared types, constants and helper functions for the Parzen window classifier.
package pwc_pkg;

    localparam int TRAIN_DEPTH = 8192;
    localparam int PIXEL_COUNT = 36;
    localparam int CLASS_COUNT = 16;

    localparam int IMAGE_W = 36;
    localparam int LABEL_W = 4;
    localparam int VOTE_W = 14;
    localparam int RADIUS_W = 3;
    localparam int STATUS_W = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int ADDR_W = (TRAIN_DEPTH > 1) ? $clog2(TRAIN_DEPTH) : 1;
    localparam int COUNT_W = $clog2(TRAIN_DEPTH + 1);
    localparam int ENTRY_W = LABEL_W + PIXEL_COUNT;
    localparam int CLASS_IDX_W = $clog2(CLASS_COUNT);
    localparam int DIST_W = $clog2(PIXEL_COUNT + 1);
    localparam int LIMIT_W = 2 * RADIUS_W;
    localparam int CMP_W = (DIST_W > LIMIT_W) ? DIST_W : LIMIT_W;

    localparam logic [VOTE_W-1:0] VOTE_MAX = {VOTE_W{1'b1}};
    localparam logic [COUNT_W-1:0] DEPTH_FULL = COUNT_W'(TRAIN_DEPTH);
    localparam logic [CLASS_IDX_W-1:0] CLASS_LAST = CLASS_IDX_W'(CLASS_COUNT - 1);
    localparam logic [LABEL_W:0] CLASS_LIMIT = (LABEL_W + 1)'(CLASS_COUNT);
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_STORED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RESULT = 2'd2;

    localparam logic REG_RADIUS = 1'b0;

    typedef struct packed {
        logic clear;
        logic inc;
        logic [CLASS_IDX_W-1:0] inc_label;
        logic pick_start;
    } vote_ctrl_t;

    typedef struct packed {
        logic done;
        logic found;
        logic [CLASS_IDX_W-1:0] best_class;
        logic [VOTE_W-1:0] best_votes;
    } vote_res_t;

    function automatic logic [DIST_W-1:0] ones_count(input logic [PIXEL_COUNT-1:0] value);
        logic [DIST_W-1:0] total;
        total = '0;
        for (int i = 0; i < PIXEL_COUNT; i++)
        begin
            total = total + DIST_W'(value[i]);
        end
        return total;
    endfunction

endpackage

### design/parzen_window_classifier.sv
// Top level of the Parzen window vote classifier for 6x6 binary images.
//
// Requests arrive on a valid/ready channel (opcode, image_bits, class_label);
// one response per request leaves on a second valid/ready channel held in an
// output register. A load request writes the image and label into the next
// free store entry and answers in the cycle after acceptance; a full store drops
// it and answers with status 1. A classify request reads every stored entry
// once, one memory word per cycle from the single read port, then walks the
// sixteen class counters one per cycle to pick the winner. A classify passes
// through the scan, drain and pick states in that order before its response
// is registered. One request is worked on at a time; a new request
// is taken in the idle state whenever the response register is empty or
// drains in that cycle. When the receiver stalls, the response stays in its
// register and no new request is taken until it leaves.
// Reset empties the store, zeroes the vote counters and sets window_radius
// to 2; the store memory itself needs no clearing pass.
// The APB port holds window_radius at address 0; pready is tied high.
module parzen_window_classifier
    import pwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 opcode,
    input  logic [IMAGE_W-1:0]   image_bits,
    input  logic [LABEL_W-1:0]   class_label,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [LABEL_W-1:0]   predicted_class,
    output logic                 class_found,
    output logic [VOTE_W-1:0]    best_votes,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_PICK  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [RADIUS_W-1:0] radius_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] scan_addr_reg, scan_addr_next;
    logic [PIXEL_COUNT-1:0] query_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic rd_pend_reg;
    logic hit_valid_reg;
    logic [CLASS_IDX_W-1:0] hit_label_reg;

    logic rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [LABEL_W-1:0] class_reg;
    logic found_reg;
    logic [VOTE_W-1:0] votes_out_reg;

    logic req_fire;
    logic cfg_write;
    logic store_full;
    logic wr_en;
    logic rd_en;
    logic [ENTRY_W-1:0] rd_data;
    logic [PIXEL_COUNT-1:0] rd_image;
    logic [LABEL_W-1:0] rd_label;
    logic [DIST_W-1:0] distance;
    logic hit;
    vote_ctrl_t vote_ctrl;
    vote_res_t vote_res;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_RADIUS);
    assign prdata = (paddr[2] == REG_RADIUS) ? PDATA_W'(radius_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_write)
        begin
            radius_reg <= pwdata[RADIUS_W-1:0];
        end
    end

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_fire = req_valid && req_ready;
    assign store_full = (count_reg == DEPTH_FULL);
    assign wr_en = req_fire && (opcode == OP_LOAD) && !store_full;

    pwc_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({class_label, image_bits[PIXEL_COUNT-1:0]}),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign rd_image = rd_data[PIXEL_COUNT-1:0];
    assign rd_label = rd_data[ENTRY_W-1:PIXEL_COUNT];
    assign distance = ones_count(rd_image ^ query_reg);
    assign hit = (CMP_W'(distance) < CMP_W'(limit_reg))
        && ({1'b0, rd_label} < CLASS_LIMIT);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_addr_next = scan_addr_reg;
        rd_en = 1'b0;
        vote_ctrl.clear = 1'b0;
        vote_ctrl.inc = hit_valid_reg;
        vote_ctrl.inc_label = hit_label_reg;
        vote_ctrl.pick_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (opcode == OP_CLASSIFY)
                    begin
                        vote_ctrl.clear = 1'b1;
                        scan_addr_next = '0;
                        state_next = S_SCAN;
                    end
                    else if (!store_full)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_addr_reg != count_reg)
                begin
                    rd_en = 1'b1;
                    scan_addr_next = scan_addr_reg + COUNT_W'(1);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_pend_reg && !hit_valid_reg)
                begin
                    vote_ctrl.pick_start = 1'b1;
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (vote_res.done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    pwc_vote u_vote (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (vote_ctrl),
        .res   (vote_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            scan_addr_reg <= '0;
            rd_pend_reg <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_addr_reg <= scan_addr_next;
            rd_pend_reg <= rd_en;
            hit_valid_reg <= rd_pend_reg && hit;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_label_reg <= rd_label[CLASS_IDX_W-1:0];
        if (req_fire && (opcode == OP_CLASSIFY))
        begin
            query_reg <= image_bits[PIXEL_COUNT-1:0];
            limit_reg <= LIMIT_W'(radius_reg) * LIMIT_W'(radius_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((req_fire && (opcode == OP_LOAD)) || vote_res.done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && (opcode == OP_LOAD))
        begin
            status_reg <= store_full ? STATUS_FULL : STATUS_STORED;
            class_reg <= '0;
            found_reg <= 1'b0;
            votes_out_reg <= '0;
        end
        else if (vote_res.done)
        begin
            status_reg <= STATUS_RESULT;
            class_reg <= vote_res.found ? LABEL_W'(vote_res.best_class) : '0;
            found_reg <= vote_res.found;
            votes_out_reg <= vote_res.best_votes;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status = status_reg;
    assign predicted_class = class_reg;
    assign class_found = found_reg;
    assign best_votes = votes_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_FULL)
    else $error("Store count ran past the store depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_addr_reg <= count_reg))
    else $error("Scan address ran past the stored entries.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (opcode == OP_LOAD)) |=> (rsp_valid && (status != STATUS_RESULT)))
    else $error("Load request did not answer in the next cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !class_found) |-> ((best_votes == '0) && (predicted_class == '0)))
    else $error("Response without a class carries votes or a class.");

endmodule

### design/pwc_store.sv
// Training store memory holding one label and image per entry, registered read.
module pwc_store
    import pwc_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [TRAIN_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/pwc_vote.sv
// Per-class vote counters with a serial arg-max pass over the classes.
module pwc_vote
    import pwc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  vote_ctrl_t ctrl,
    output vote_res_t  res
);

    logic [VOTE_W-1:0] votes_reg [CLASS_COUNT];
    logic pick_busy_reg;
    logic [CLASS_IDX_W-1:0] pick_idx_reg;
    logic [VOTE_W-1:0] best_reg;
    logic [CLASS_IDX_W-1:0] best_class_reg;
    logic found_reg;
    logic done_reg;

    logic [CLASS_IDX_W-1:0] rd_idx;
    logic [VOTE_W-1:0] rd_vote;

    always_comb
    begin
        rd_idx = pick_busy_reg ? pick_idx_reg : ctrl.inc_label;
        rd_vote = votes_reg[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                votes_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                votes_reg[i] <= '0;
            end
        end
        else if (ctrl.inc && !pick_busy_reg && (rd_vote != VOTE_MAX))
        begin
            votes_reg[rd_idx] <= rd_vote + VOTE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_busy_reg <= 1'b0;
            pick_idx_reg <= '0;
            best_reg <= '0;
            best_class_reg <= '0;
            found_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.pick_start)
            begin
                pick_busy_reg <= 1'b1;
                pick_idx_reg <= '0;
                best_reg <= '0;
                best_class_reg <= '0;
                found_reg <= 1'b0;
            end
            else if (pick_busy_reg)
            begin
                if (rd_vote > best_reg)
                begin
                    best_reg <= rd_vote;
                    best_class_reg <= pick_idx_reg;
                    found_reg <= 1'b1;
                end
                if (pick_idx_reg == CLASS_LAST)
                begin
                    pick_busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    pick_idx_reg <= pick_idx_reg + CLASS_IDX_W'(1);
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.found = found_reg;
    assign res.best_class = best_class_reg;
    assign res.best_votes = best_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Parzen window classifier with APB radius setup.
module tb_top;
    import pwc_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [LABEL_W-1:0]  cls;
        logic                found;
        logic [VOTE_W-1:0]   votes;
    } response_t;

    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 100;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    logic                opcode;
    logic [IMAGE_W-1:0]  image_bits;
    logic [LABEL_W-1:0]  class_label;
    logic                rsp_valid;
    logic                rsp_ready;
    logic [STATUS_W-1:0] status;
    logic [LABEL_W-1:0]  predicted_class;
    logic                class_found;
    logic [VOTE_W-1:0]   best_votes;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    response_t           expected_responses[$];
    logic [IMAGE_W-1:0]  train_images [TRAIN_DEPTH];
    logic [LABEL_W-1:0]  train_labels [TRAIN_DEPTH];
    int                  train_count;
    logic [RADIUS_W-1:0] window_radius;
    int                  mismatch_count = 0;
    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    bit                  hold_go = 1'b0;

    parzen_window_classifier dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic response_t predict_response(input logic op,
                                                   input logic [IMAGE_W-1:0] img,
                                                   input logic [LABEL_W-1:0] lbl);
        response_t r;
        int votes [CLASS_COUNT];
        int limit;
        int best;
        r.status = STATUS_STORED;
        r.cls = '0;
        r.found = 1'b0;
        r.votes = '0;
        if (op == OP_LOAD)
        begin
            if (train_count >= TRAIN_DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                train_images[train_count] = img;
                train_labels[train_count] = lbl;
                train_count++;
            end
            return r;
        end
        limit = int'(window_radius) * int'(window_radius);
        foreach (votes[c])
        begin
            votes[c] = 0;
        end
        for (int k = 0; k < train_count; k++)
        begin
            if ($countones(img ^ train_images[k]) < limit
                && votes[train_labels[k]] < int'(VOTE_MAX))
            begin
                votes[train_labels[k]]++;
            end
        end
        best = 0;
        r.status = STATUS_RESULT;
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            if (votes[c] > best)
            begin
                best = votes[c];
                r.cls = LABEL_W'(c);
                r.found = 1'b1;
            end
        end
        r.votes = VOTE_W'(best);
        return r;
    endfunction

    function automatic logic [IMAGE_W-1:0] random_image();
        return IMAGE_W'({$urandom(), $urandom()});
    endfunction

    task automatic send_request(input logic op, input logic [IMAGE_W-1:0] img,
                                input logic [LABEL_W-1:0] lbl);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        opcode <= op;
        image_bits <= img;
        class_label <= lbl;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        expected_responses.insert(expected_responses.size(), predict_response(op, img, lbl));
        @(negedge clk);
    endtask

    task automatic wait_for_responses();
        req_valid <= 1'b0;
        while (expected_responses.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_window_radius(input logic [RADIUS_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * REG_RADIUS);
        pwdata <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        window_radius = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== PDATA_W'(value))
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("Radius readback: expected %0d, got %0d", value, prdata);
            end
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_empty_store();
        send_request(OP_CLASSIFY, '0, '0);
        send_request(OP_CLASSIFY, '1, '1);
        send_request(OP_CLASSIFY, random_image(), LABEL_W'($urandom_range(15)));
        wait_for_responses();
    endtask

    task automatic test_directed_votes();
        send_request(OP_LOAD, '0, LABEL_W'(0));
        send_request(OP_LOAD, '1, LABEL_W'(15));
        send_request(OP_LOAD, IMAGE_W'(36'h0_0000_0007), LABEL_W'(5));
        send_request(OP_LOAD, IMAGE_W'(36'h0_0000_0001), LABEL_W'(5));
        send_request(OP_LOAD, IMAGE_W'(36'h8_0000_0000), LABEL_W'(9));
        send_request(OP_CLASSIFY, '0, '0);
        send_request(OP_CLASSIFY, '1, '0);
        send_request(OP_CLASSIFY, IMAGE_W'(36'h0_0000_0003), '0);
        send_request(OP_LOAD, IMAGE_W'(36'h8_0000_0003), LABEL_W'(9));
        send_request(OP_CLASSIFY, IMAGE_W'(36'h8_0000_0001), '0);
        wait_for_responses();
    endtask

    task automatic test_radius_sweep();
        logic [RADIUS_W-1:0] settings [4] = '{3'd0, 3'd1, 3'd7, 3'd3};
        foreach (settings[i])
        begin
            set_window_radius(settings[i]);
            send_request(OP_CLASSIFY, '0, '0);
            send_request(OP_CLASSIFY, '1, '0);
            send_request(OP_CLASSIFY, IMAGE_W'(36'h8_0000_0001), '0);
            wait_for_responses();
        end
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go = 1'b1;
        for (int n = 0; n < 8; n++)
        begin
            send_request((n % 2 != 0) ? OP_CLASSIFY : OP_LOAD, random_image(), LABEL_W'(n));
        end
        wait_for_responses();
    endtask

    task automatic test_random_traffic();
        logic [IMAGE_W-1:0] img;
        logic [LABEL_W-1:0] lbl;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 25 == 0)
            begin
                wait_for_responses();
                set_window_radius(RADIUS_W'($urandom_range(7)));
                tx_idle_pct = (n == 50) ? 0 : 16;
                rx_idle_pct = tx_idle_pct;
            end
            img = random_image();
            if (train_count > 0 && $urandom_range(99) < 70)
            begin
                img = train_images[$urandom_range(train_count - 1)];
                repeat ($urandom_range(4))
                begin
                    img[$urandom_range(IMAGE_W - 1)] ^= 1'b1;
                end
            end
            lbl = ($urandom_range(99) < 80) ? LABEL_W'($urandom_range(3))
                                            : LABEL_W'($urandom_range(15));
            if ($urandom_range(99) < 35)
            begin
                send_request(OP_LOAD, img, lbl);
            end
            else
            begin
                send_request(OP_CLASSIFY, img, lbl);
            end
        end
        wait_for_responses();
    endtask

    task automatic test_store_full();
        set_window_radius(RADIUS_W'(7));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (train_count < TRAIN_DEPTH)
        begin
            send_request(OP_LOAD, random_image(),
                         ($urandom_range(9) == 0) ? LABEL_W'($urandom_range(15))
                                                  : LABEL_W'(6));
        end
        tx_idle_pct = 16;
        rx_idle_pct = 16;
        repeat (4)
        begin
            send_request(OP_LOAD, random_image(), LABEL_W'($urandom_range(15)));
        end
        send_request(OP_CLASSIFY, random_image(), '0);
        wait_for_responses();
        set_window_radius(RADIUS_W'(4));
        send_request(OP_CLASSIFY, train_images[0], '0);
        send_request(OP_LOAD, random_image(), '1);
        wait_for_responses();
        set_window_radius(RADIUS_W'(0));
        send_request(OP_CLASSIFY, train_images[1], '0);
        wait_for_responses();
    endtask

    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                begin
                    @(negedge clk);
                end
                hold_go = 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        response_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_responses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("Response with no request pending: status %0d class %0d",
                             status, predicted_class);
                end
            end
            else
            begin
                want = expected_responses.pop_front();
                if (status !== want.status || predicted_class !== want.cls
                    || class_found !== want.found || best_votes !== want.votes)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Expected status %0d class %0d found %0d votes %0d, got %0d %0d %0d %0d",
                                 want.status, want.cls, want.found, want.votes,
                                 status, predicted_class, class_found, best_votes);
                    end
                end
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        opcode = OP_LOAD;
        image_bits = '0;
        class_label = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        train_count = 0;
        window_radius = RADIUS_RESET;
        repeat (9)
        begin
            @(negedge clk);
        end
        rst_n <= 1'b1;
        tx_idle_pct = 16;
        rx_idle_pct = 16;
        test_empty_store();
        test_directed_votes();
        test_radius_sweep();
        test_output_stall();
        test_random_traffic();
        test_store_full();
        wait_for_responses();
        repeat (40)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0 && expected_responses.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### parzen_window_classifier.f
design/pwc_pkg.sv
design/pwc_store.sv
design/pwc_vote.sv
design/parzen_window_classifier.sv
tb/tb_top.sv
